// ===== src/cmac_pkg.sv =====
// Shared types and constants for the multichannel convolution MAC core.
// No dependencies; all modules import this package.
package cmac_pkg;

  // Command kinds; the encoding matches the mode field of an input item
  typedef enum logic [1:0] {
    CMD_FEAT    = 2'd0,
    CMD_WGT     = 2'd1,
    CMD_BIAS    = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_kind_t;

  // Back-end sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // One classified command as it waits between front and back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [4:0]  oc;
    logic [3:0]  ic;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [7:0]  value;
  } cmd_t;

  // Results per compute are capped at this many output channels
  localparam int MAX_RESULTS = 32;

  // Command queue depth and its pointer and count widths
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

endpackage

// ===== src/cmac_if.sv =====
// Handshake interfaces for the input item and result channels.
// Depends on nothing; field widths are fixed by the item formats.
interface cmac_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [4:0] out_channel_sel;
  logic [3:0] in_channel_sel;
  logic [1:0] tap_row;
  logic [1:0] tap_col;
  logic [7:0] load_value;

  modport source (output valid, output mode, output out_channel_sel,
                  output in_channel_sel, output tap_row, output tap_col,
                  output load_value, input ready);
  modport sink   (input valid, input mode, input out_channel_sel,
                  input in_channel_sel, input tap_row, input tap_col,
                  input load_value, output ready);
endinterface

interface cmac_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  out_channel;
  logic [23:0] conv_value;
  logic [28:0] running_total;
  logic        last;

  modport source (output valid, output out_channel, output conv_value,
                  output running_total, output last, input ready);
  modport sink   (input valid, input out_channel, input conv_value,
                  input running_total, input last, output ready);
endinterface

// ===== src/cmac_queue.sv =====
// Short command queue between the front classifier and the back engine.
// Depends on cmac_pkg for cmd_t and the queue sizes.
module cmac_queue
  import cmac_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  cmd_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;

  assign full      = (count_r == Q_CW'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/cmac_front.sv =====
// Front end: accepts input items, drops loads that address nothing,
// and pushes the rest as commands. Depends on cmac_pkg and cmac_if.
module cmac_front
  import cmac_pkg::*;
#(
  parameter int IN_CH    = 16,
  parameter int OUT_CH   = 32,
  parameter int KERNEL_W = 3,
  parameter int KERNEL_H = 3
) (
  cmac_in_if.sink in_bus,
  input  logic    q_full,
  output logic    q_push,
  output cmd_t    q_data
);

  logic tap_ok;
  logic oc_ok;
  logic keep;

  assign in_bus.ready = !q_full;

  assign tap_ok = (int'(in_bus.in_channel_sel) < IN_CH) &&
                  (int'(in_bus.tap_row) < KERNEL_H) &&
                  (int'(in_bus.tap_col) < KERNEL_W);
  assign oc_ok  = (int'(in_bus.out_channel_sel) < OUT_CH);

  // Classify the item and decide whether it reaches the back end
  always_comb begin
    q_data.oc    = in_bus.out_channel_sel;
    q_data.ic    = in_bus.in_channel_sel;
    q_data.row   = in_bus.tap_row;
    q_data.col   = in_bus.tap_col;
    q_data.value = in_bus.load_value;
    unique case (in_bus.mode)
      CMD_FEAT: begin
        q_data.kind = CMD_FEAT;
        keep        = tap_ok;
      end
      CMD_WGT: begin
        q_data.kind = CMD_WGT;
        keep        = tap_ok && oc_ok;
      end
      CMD_BIAS: begin
        q_data.kind = CMD_BIAS;
        keep        = oc_ok;
      end
      default: begin
        q_data.kind = CMD_COMPUTE;
        keep        = 1'b1;
      end
    endcase
  end

  assign q_push = in_bus.valid && !q_full && keep;

endmodule

// ===== src/cmac_back.sv =====
// Back end: owns the feature, weight and bias stores, executes loads and
// sequences the multiply-accumulate pipeline. Depends on cmac_pkg, cmac_if.
module cmac_back
  import cmac_pkg::*;
#(
  parameter int IN_CH    = 16,
  parameter int OUT_CH   = 32,
  parameter int KERNEL_W = 3,
  parameter int KERNEL_H = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  cmac_out_if.source  out_bus
);

  localparam int FD    = IN_CH * KERNEL_H * KERNEL_W;
  localparam int NCH   = (OUT_CH < MAX_RESULTS) ? OUT_CH : MAX_RESULTS;
  localparam int WD    = NCH * FD;
  localparam int FA_W  = (FD > 1) ? $clog2(FD) : 1;
  localparam int WA_W  = (WD > 1) ? $clog2(WD) : 1;
  localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;

  typedef struct packed {
    logic       valid;
    logic       first_tap;
    logic       last_tap;
    logic       first_ch;
    logic       last_ch;
    logic [4:0] ch;
  } stage_ctrl_t;

  state_t          state_r, state_nxt;
  logic [FA_W-1:0] tap_r, tap_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic [WA_W-1:0] waddr_r, waddr_nxt;

  logic            en;
  logic            issue;
  logic            tap_end;
  logic            ch_end;
  logic            start;
  logic [FA_W-1:0] ld_faddr;
  logic [WA_W-1:0] ld_waddr;
  logic            feat_we, wgt_we, bias_we;

  logic [7:0] feat_mem [FD];
  logic [7:0] wgt_mem  [WD];
  logic [7:0] bias_mem [NCH];

  logic [7:0]  feat_rd_r, wgt_rd_r, bias_rd_r;
  stage_ctrl_t p1_r, p2_r, p3_r, p1_nxt;
  logic [15:0] prod_r;
  logic [7:0]  bias2_r;
  logic [23:0] acc_r, acc_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  out_ch_r;
  logic [23:0] out_conv_r;
  logic [28:0] out_total_r;
  logic        out_last_r;

  // Whole pipeline holds while a result waits to be taken
  assign en      = !(out_valid_r && !out_bus.ready);
  assign tap_end = (tap_r == FA_W'(FD - 1));
  assign ch_end  = (ch_r == CH_W'(NCH - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_not_empty && q_head.kind == CMD_COMPUTE) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (en && tap_end && ch_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    unique case (state_r)
      ST_IDLE: q_pop = q_not_empty;
      ST_RUN:  issue = en;
      default: begin
        q_pop = 1'b0;
        issue = 1'b0;
      end
    endcase
  end

  assign start = q_pop && (q_head.kind == CMD_COMPUTE);

  // Advance the tap, channel and weight address counters
  always_comb begin
    tap_nxt   = tap_r;
    ch_nxt    = ch_r;
    waddr_nxt = waddr_r;
    if (start) begin
      tap_nxt   = '0;
      ch_nxt    = '0;
      waddr_nxt = '0;
    end else if (issue) begin
      waddr_nxt = waddr_r + 1'b1;
      if (tap_end) begin
        tap_nxt = '0;
        ch_nxt  = ch_r + 1'b1;
      end else begin
        tap_nxt = tap_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= '0;
      ch_r    <= '0;
      waddr_r <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      ch_r    <= ch_nxt;
      waddr_r <= waddr_nxt;
    end
  end

  // Decode load addresses
  assign ld_faddr = FA_W'((int'(q_head.ic) * KERNEL_H + int'(q_head.row)) * KERNEL_W
                          + int'(q_head.col));
  assign ld_waddr = WA_W'(int'(q_head.oc) * FD + int'(ld_faddr));
  assign feat_we  = q_pop && (q_head.kind == CMD_FEAT);
  assign wgt_we   = q_pop && (q_head.kind == CMD_WGT);
  assign bias_we  = q_pop && (q_head.kind == CMD_BIAS);

  // Feature store
  always_ff @(posedge clk) begin
    if (feat_we) begin
      feat_mem[ld_faddr] <= q_head.value;
    end
    if (issue) begin
      feat_rd_r <= feat_mem[tap_r];
    end
  end

  // Weight store
  always_ff @(posedge clk) begin
    if (wgt_we) begin
      wgt_mem[ld_waddr] <= q_head.value;
    end
    if (issue) begin
      wgt_rd_r <= wgt_mem[waddr_r];
    end
  end

  // Bias store
  always_ff @(posedge clk) begin
    if (bias_we) begin
      bias_mem[q_head.oc[CH_W-1:0]] <= q_head.value;
    end
    if (issue) begin
      bias_rd_r <= bias_mem[ch_r];
    end
  end

  // Tag each issued tap
  always_comb begin
    p1_nxt.valid     = issue;
    p1_nxt.first_tap = (tap_r == '0);
    p1_nxt.last_tap  = tap_end;
    p1_nxt.first_ch  = (ch_r == '0);
    p1_nxt.last_ch   = ch_end;
    p1_nxt.ch        = 5'(ch_r);
  end

  // Seed with bias on the first tap, then accumulate products
  always_comb begin
    if (p2_r.first_tap) begin
      acc_nxt = 24'(prod_r) + 24'(bias2_r);
    end else begin
      acc_nxt = acc_r + 24'(prod_r);
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= '0;
      p2_r <= '0;
      p3_r <= '0;
    end else if (en) begin
      p1_r <= p1_nxt;
      p2_r <= p1_r;
      p3_r <= p2_r;
    end
  end

  // Pipeline data: multiply, then accumulate
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= 16'(feat_rd_r) * 16'(wgt_rd_r);
      bias2_r <= bias_rd_r;
      if (p2_r.valid) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // Hold the result until its transfer; drop it once taken
  always_comb begin
    if (en && p3_r.valid && p3_r.last_tap) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload and running total
  always_ff @(posedge clk) begin
    if (en && p3_r.valid && p3_r.last_tap) begin
      out_ch_r    <= p3_r.ch;
      out_conv_r  <= acc_r;
      out_last_r  <= p3_r.last_ch;
      out_total_r <= (p3_r.first_ch ? 29'd0 : out_total_r) + 29'(acc_r);
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.out_channel   = out_ch_r;
  assign out_bus.conv_value    = out_conv_r;
  assign out_bus.running_total = out_total_r;
  assign out_bus.last          = out_last_r;

endmodule

// ===== src/conv_multichannel_mac.sv =====
// Loads stream at one per cycle while the back end is idle; during a compute up to four
// commands wait in the queue, then the input stalls until the compute ends.
// A compute holds the back end while it issues min(OUT_CH,32)*IN_CH*KERNEL_H*KERNEL_W taps
// (4608 at the defaults), one tap per cycle; each result passes the store read, product,
// accumulator and result registers before it is valid; a waiting result stalls the taps.
// Reset clears the queue, sequencer and pipeline control; the stores get no clearing pass.
module conv_multichannel_mac
  import cmac_pkg::*;
#(
  parameter int IN_CH    = 16,
  parameter int OUT_CH   = 32,
  parameter int KERNEL_W = 3,
  parameter int KERNEL_H = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  cmac_in_if.sink    in_bus,
  cmac_out_if.source out_bus
);

  logic q_full;
  logic q_push;
  cmd_t q_data;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_head;

  // Classify incoming items
  cmac_front #(
    .IN_CH    (IN_CH),
    .OUT_CH   (OUT_CH),
    .KERNEL_W (KERNEL_W),
    .KERNEL_H (KERNEL_H)
  ) u_front (
    .in_bus (in_bus),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  // Decouple front and back
  cmac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Execute loads and computes
  cmac_back #(
    .IN_CH    (IN_CH),
    .OUT_CH   (OUT_CH),
    .KERNEL_W (KERNEL_W),
    .KERNEL_H (KERNEL_H)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_bus     (out_bus)
  );

endmodule
